@@ rtl/core/fse_pkg.sv @@
package fse_pkg;

   localparam int MAX_FRACTIONS = 32;
   localparam int MAX_PRIMES    = 8;
   localparam int EXP_WIDTH     = 24;
   localparam int SUM_W         = EXP_WIDTH + 1;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 3;
   localparam int ENTRY_W = 7;
   localparam int FCNT_W  = 6;
   localparam int PCNT_W  = 4;
   localparam int STEP_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [FCNT_W-1:0] FCNT_RESET  = FCNT_W'(1);
   localparam logic [PCNT_W-1:0] PCNT_RESET  = PCNT_W'(1);
   localparam logic [STEP_W-1:0] LIMIT_RESET = STEP_W'(10000);
   localparam logic [FCNT_W-1:0] FCNT_MAX    = FCNT_W'(MAX_FRACTIONS);
   localparam logic [PCNT_W-1:0] PCNT_MAX    = PCNT_W'(MAX_PRIMES);

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_STEP    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRACTION_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT     = 2'd2;

   typedef logic [MAX_PRIMES-1:0][ENTRY_W-1:0] row_type;
   typedef logic [EXP_WIDTH-1:0] exp_type;

   typedef struct packed {
      logic restart;
      logic apply;
   } vec_ctrl_type;

endpackage

@@ rtl/core/fse_table.sv @@
module fse_table
   import fse_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ROW_W-1:0]   wr_row,
   input  logic [COL_W-1:0]   wr_col,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [ROW_W-1:0]   rd_row,
   output row_type            rd_data
);

   row_type mem [MAX_FRACTIONS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_col] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fse_vector.sv @@
module fse_vector
   import fse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  vec_ctrl_type      ctrl,
   input  row_type           row,
   input  logic [PCNT_W-1:0] cols_used,
   output logic              fits,
   output logic              ovf,
   output logic              zero
);

   exp_type exp_ff [MAX_PRIMES];
   exp_type exp_in [MAX_PRIMES];
   logic [ENTRY_W-1:0] mag [MAX_PRIMES];
   logic [SUM_W-1:0]   sum [MAX_PRIMES];
   logic [MAX_PRIMES-1:0] lane_use;
   logic [MAX_PRIMES-1:0] lane_ok;
   logic [MAX_PRIMES-1:0] lane_ovf;
   logic [MAX_PRIMES-1:0] lane_zero;

   // lane status, independent of the update control
   always_comb begin
      for (int c = 0; c < MAX_PRIMES; c++) begin
         lane_use[c] = PCNT_W'(c) < cols_used;
         mag[c] = ENTRY_W'(-$signed(row[c]));
         sum[c] = SUM_W'(exp_ff[c]) + SUM_W'(row[c][ENTRY_W-2:0]);
         lane_ok[c] = !lane_use[c] || !row[c][ENTRY_W-1] ||
                      (exp_ff[c] >= EXP_WIDTH'(mag[c]));
         lane_zero[c] = !lane_use[c] || (exp_ff[c] == '0);
         lane_ovf[c] = lane_use[c] && !row[c][ENTRY_W-1] && sum[c][SUM_W-1];
      end
   end

   always_comb begin
      for (int c = 0; c < MAX_PRIMES; c++) begin
         exp_in[c] = exp_ff[c];
         if (ctrl.restart) begin
            exp_in[c] = (c == 0) ? EXP_WIDTH'(1) : '0;
         end else if (ctrl.apply && lane_use[c]) begin
            if (row[c][ENTRY_W-1]) begin
               exp_in[c] = exp_ff[c] - EXP_WIDTH'(mag[c]);
            end else if (lane_ovf[c]) begin
               exp_in[c] = '1;
            end else begin
               exp_in[c] = sum[c][EXP_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < MAX_PRIMES; c++) begin
         if (reset) begin
            exp_ff[c] <= (c == 0) ? EXP_WIDTH'(1) : '0;
         end else begin
            exp_ff[c] <= exp_in[c];
         end
      end
   end

   assign fits = &lane_ok;
   assign ovf  = |lane_ovf;
   assign zero = &lane_zero;

endmodule

@@ rtl/core/fractran_step_engine_unit.sv @@
// channel  direction  handshake           payload
// req      in         req_valid/req_stall opcode, fraction_index, prime_index, entry_value
// rsp      out        rsp_valid/rsp_stall halted, applied_index, step_count, limit_reached,
//                                         all_zero, overflow
// csr      in         csr_valid/csr_ready csr_index, csr_data
//
// Write, restart and idle step items pass from accept through ST_REPORT to the result register.
// Running step: rows are examined in ST_SCAN, then ST_REPORT loads the result register and
// the next item is taken in ST_IDLE; one fraction row is read and checked per cycle from the
// table memory.
// Reset is synchronous; the exponent vector returns to two. Table contents are kept.
// A new item is taken while an earlier result waits under rsp_stall.
module fractran_step_engine_unit
   import fse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [ROW_W-1:0]      req_fraction_index,
   input  logic [COL_W-1:0]      req_prime_index,
   input  logic signed [ENTRY_W-1:0] req_entry_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_halted,
   output logic [ROW_W-1:0]      rsp_applied_index,
   output logic [STEP_W-1:0]     rsp_step_count,
   output logic                  rsp_limit_reached,
   output logic                  rsp_all_zero,
   output logic                  rsp_overflow,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [FCNT_W-1:0] fraction_count_ff;
   logic [PCNT_W-1:0] prime_count_ff;
   logic [STEP_W-1:0] step_limit_ff;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              stopped_ff, stopped_in;
   logic              applied_ff, applied_in;
   logic [ROW_W-1:0]  which_ff, which_in;
   logic              ovf_ff, ovf_in;
   logic [FCNT_W-1:0] issue_row_ff, issue_row_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [ROW_W-1:0]  chk_row_ff, chk_row_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_halted_ff, rsp_halted_in;
   logic [ROW_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [STEP_W-1:0] rsp_steps_ff, rsp_steps_in;
   logic              rsp_limit_ff, rsp_limit_in;
   logic              rsp_zero_ff, rsp_zero_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              accept;
   logic [FCNT_W-1:0] rows_used;
   logic [PCNT_W-1:0] cols_used;
   logic              table_we;
   row_type           row_data;
   vec_ctrl_type      vec_ctrl;
   logic              fits, vec_ovf, vec_zero;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rows_used = (fraction_count_ff > FCNT_MAX) ? FCNT_MAX : fraction_count_ff;
   assign cols_used = (prime_count_ff > PCNT_MAX) ? PCNT_MAX : prime_count_ff;
   assign table_we  = accept && (req_opcode == OP_WRITE);

   fse_table u_table (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_row  (req_fraction_index),
      .wr_col  (req_prime_index),
      .wr_data (req_entry_value),
      .rd_row  (issue_row_ff[ROW_W-1:0]),
      .rd_data (row_data)
   );

   fse_vector u_vector (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (vec_ctrl),
      .row       (row_data),
      .cols_used (cols_used),
      .fits      (fits),
      .ovf       (vec_ovf),
      .zero      (vec_zero)
   );

   always_comb begin
      logic load;
      state_in      = state_ff;
      steps_in      = steps_ff;
      stopped_in    = stopped_ff;
      applied_in    = applied_ff;
      which_in      = which_ff;
      ovf_in        = ovf_ff;
      issue_row_in  = issue_row_ff;
      chk_valid_in  = 1'b0;
      chk_row_in    = chk_row_ff;
      vec_ctrl      = '0;
      load          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_halted_in = rsp_halted_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_steps_in  = rsp_steps_ff;
      rsp_limit_in  = rsp_limit_ff;
      rsp_zero_in   = rsp_zero_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               applied_in = 1'b0;
               ovf_in     = 1'b0;
               state_in   = ST_REPORT;
               if (req_opcode == OP_RESTART) begin
                  vec_ctrl.restart = 1'b1;
                  steps_in   = '0;
                  stopped_in = 1'b0;
               end else if (req_opcode == OP_STEP && !stopped_ff &&
                            steps_ff < step_limit_ff) begin
                  if (rows_used == '0) begin
                     stopped_in = 1'b1;
                  end else begin
                     issue_row_in = '0;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (issue_row_ff < rows_used) begin
               chk_valid_in = 1'b1;
               chk_row_in   = issue_row_ff[ROW_W-1:0];
               issue_row_in = issue_row_ff + FCNT_W'(1);
            end
            if (chk_valid_ff) begin
               if (fits) begin
                  vec_ctrl.apply = 1'b1;
                  applied_in = 1'b1;
                  which_in   = chk_row_ff;
                  ovf_in     = vec_ovf;
                  steps_in   = steps_ff + STEP_W'(1);
                  state_in   = ST_REPORT;
               end else if (FCNT_W'(chk_row_ff) + FCNT_W'(1) == rows_used) begin
                  stopped_in = 1'b1;
                  state_in   = ST_REPORT;
               end
            end
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_halted_in = stopped_ff;
         rsp_index_in  = applied_ff ? which_ff : '0;
         rsp_steps_in  = steps_ff;
         rsp_limit_in  = steps_ff >= step_limit_ff;
         rsp_zero_in   = stopped_ff && vec_zero;
         rsp_ovf_in    = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         fraction_count_ff <= FCNT_RESET;
         prime_count_ff    <= PCNT_RESET;
         step_limit_ff     <= LIMIT_RESET;
         steps_ff          <= '0;
         stopped_ff        <= 1'b0;
         applied_ff        <= 1'b0;
         ovf_ff            <= 1'b0;
         issue_row_ff      <= '0;
         chk_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         stopped_ff   <= stopped_in;
         applied_ff   <= applied_in;
         ovf_ff       <= ovf_in;
         issue_row_ff <= issue_row_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FRACTION_COUNT: fraction_count_ff <= csr_data[FCNT_W-1:0];
               CSR_PRIME_COUNT:    prime_count_ff    <= csr_data[PCNT_W-1:0];
               CSR_STEP_LIMIT:     step_limit_ff     <= csr_data[STEP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      which_ff      <= which_in;
      chk_row_ff    <= chk_row_in;
      rsp_halted_ff <= rsp_halted_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_steps_ff  <= rsp_steps_in;
      rsp_limit_ff  <= rsp_limit_in;
      rsp_zero_ff   <= rsp_zero_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_halted        = rsp_halted_ff;
   assign rsp_applied_index = rsp_index_ff;
   assign rsp_step_count    = rsp_steps_ff;
   assign rsp_limit_reached = rsp_limit_ff;
   assign rsp_all_zero      = rsp_zero_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import fse_pkg::*;

   localparam logic [1:0]           OP_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                   ITEM_TARGET = 1550;
   localparam int                   CYCLE_LIMIT = 1000000;
   localparam int                   DRAIN_WAIT  = 40;
   localparam longint               EXP_MAX     = (longint'(1) << EXP_WIDTH) - 1;

   typedef struct packed {
      logic              halted;
      logic [ROW_W-1:0]  applied;
      logic [STEP_W-1:0] steps;
      logic              limit;
      logic              zero;
      logic              ovf;
   } run_status_type;

   typedef struct packed {
      logic [1:0]                op;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic signed [ENTRY_W-1:0] val;
      logic                      known;
      run_status_type            want;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_opcode = OP_WRITE;
   logic [ROW_W-1:0]          req_fraction_index = '0;
   logic [COL_W-1:0]          req_prime_index = '0;
   logic signed [ENTRY_W-1:0] req_entry_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_halted;
   logic [ROW_W-1:0]          rsp_applied_index;
   logic [STEP_W-1:0]         rsp_step_count;
   logic                      rsp_limit_reached;
   logic                      rsp_all_zero;
   logic                      rsp_overflow;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // engine state as tracked by the testbench
   logic signed [ENTRY_W-1:0] frac_tab [MAX_FRACTIONS][MAX_PRIMES];
   exp_type                   expo [MAX_PRIMES];
   logic [STEP_W-1:0]         steps_done;
   logic                      run_halted;
   logic [FCNT_W-1:0]         cfg_rows;
   logic [PCNT_W-1:0]         cfg_cols;
   logic [STEP_W-1:0]         cfg_limit;

   run_status_type due_status [$];
   plan_row_type   plan [$];
   int             errors = 0;
   int             items_sent = 0;
   int             results_seen = 0;
   int             burst_left = 0;
   int             cycle_count = 0;

   fractran_step_engine_unit dut (.*);

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic flag_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d (result %0d, t=%0t)",
               what, got, want, results_seen, $time);
   endtask

   function automatic void restart_vector();
      foreach (expo[c]) expo[c] = '0;
      expo[0] = exp_type'(1);
      steps_done = '0;
      run_halted = 1'b0;
   endfunction

   function automatic int rows_in_use();
      return (cfg_rows > MAX_FRACTIONS) ? MAX_FRACTIONS : int'(cfg_rows);
   endfunction

   function automatic int cols_in_use();
      return (cfg_cols > MAX_PRIMES) ? MAX_PRIMES : int'(cfg_cols);
   endfunction

   function automatic run_status_type advance_engine(logic [1:0] op, logic [ROW_W-1:0] fi,
         logic [COL_W-1:0] pi, logic signed [ENTRY_W-1:0] val);
      run_status_type st;
      int             nr;
      int             nc;
      int             hit;
      int             e;
      logic           fits;
      logic           sat;
      logic           zero;
      longint         v;
      nr = rows_in_use();
      nc = cols_in_use();
      hit = -1;
      sat = 1'b0;
      if (op == OP_WRITE) begin
         frac_tab[fi][pi] = val;
      end else if (op == OP_RESTART) begin
         restart_vector();
      end else if (op == OP_STEP && !run_halted && steps_done < cfg_limit) begin
         for (int r = 0; r < nr && hit < 0; r++) begin
            fits = 1'b1;
            for (int c = 0; c < nc; c++) begin
               e = frac_tab[r][c];
               if (e < 0 && longint'(expo[c]) < longint'(-e)) fits = 1'b0;
            end
            if (fits) hit = r;
         end
         if (hit >= 0) begin
            for (int c = 0; c < nc; c++) begin
               e = frac_tab[hit][c];
               v = longint'(expo[c]);
               if (e < 0) begin
                  v = v + e;
               end else if (v > EXP_MAX - e) begin
                  v = EXP_MAX;
                  sat = 1'b1;
               end else begin
                  v = v + e;
               end
               expo[c] = exp_type'(v);
            end
            steps_done = steps_done + STEP_W'(1);
         end else begin
            run_halted = 1'b1;
         end
      end
      zero = run_halted;
      for (int c = 0; c < nc; c++)
         if (expo[c] != '0) zero = 1'b0;
      st.halted  = run_halted;
      st.applied = (hit >= 0) ? ROW_W'(hit) : '0;
      st.steps   = steps_done;
      st.limit   = (steps_done >= cfg_limit);
      st.zero    = zero;
      st.ovf     = sat;
      return st;
   endfunction

   function automatic plan_row_type entry(logic [1:0] op, int row, int col, int val,
         bit known, bit h, int s, bit z);
      plan_row_type p;
      p.op = op;
      p.row = ROW_W'(row);
      p.col = COL_W'(col);
      p.val = ENTRY_W'(val);
      p.known = known;
      p.want = '0;
      p.want.halted = h;
      p.want.steps = STEP_W'(s);
      p.want.zero = z;
      return p;
   endfunction

   function automatic logic signed [ENTRY_W-1:0] program_value();
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) return ENTRY_W'(int'($urandom_range(0, 6)) - 3);
      else if (k < 9) return ENTRY_W'(int'($urandom_range(0, 16)) - 8);
      return ENTRY_W'($urandom_range(0, 127));
   endfunction

   task automatic offer_item(logic [1:0] op, logic [ROW_W-1:0] fi, logic [COL_W-1:0] pi,
         logic signed [ENTRY_W-1:0] val, bit known, run_status_type want);
      run_status_type guess;
      int             gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_fraction_index <= fi;
      req_prime_index <= pi;
      req_entry_value <= val;
      do @(posedge clock); while (req_stall);
      guess = advance_engine(op, fi, pi, val);
      due_status = {due_status, (known ? want : guess)};
      items_sent++;
      burst_left--;
   endtask

   task automatic offer_random(logic [1:0] op);
      offer_item(op, ROW_W'($urandom), COL_W'($urandom), ENTRY_W'($urandom), 1'b0, '0);
   endtask

   task automatic drain_engine();
      @(negedge clock) req_valid <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic put_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRACTION_COUNT: cfg_rows = data[FCNT_W-1:0];
         CSR_PRIME_COUNT:    cfg_cols = data[PCNT_W-1:0];
         CSR_STEP_LIMIT:     cfg_limit = data[STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(int fc, int pc, int lim);
      put_csr(CSR_FRACTION_COUNT, {(CSR_DATA_W-FCNT_W)'($urandom), FCNT_W'(fc)});
      put_csr(CSR_PRIME_COUNT, {(CSR_DATA_W-PCNT_W)'($urandom), PCNT_W'(pc)});
      put_csr(CSR_STEP_LIMIT, CSR_DATA_W'(lim));
      put_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // result side: stall pattern, long hold-offs, checking
   initial begin
      int             stall_mode;
      int             mode_left;
      int             hold_left;
      run_status_type want;
      stall_mode = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (due_status.size() == 0) begin
               flag_mismatch("result with nothing pending", rsp_step_count, -1);
            end else begin
               want = due_status.pop_front();
               if (rsp_halted !== want.halted)
                  flag_mismatch("halted", rsp_halted, want.halted);
               if (rsp_applied_index !== want.applied)
                  flag_mismatch("applied_index", rsp_applied_index, want.applied);
               if (rsp_step_count !== want.steps)
                  flag_mismatch("step_count", rsp_step_count, want.steps);
               if (rsp_limit_reached !== want.limit)
                  flag_mismatch("limit_reached", rsp_limit_reached, want.limit);
               if (rsp_all_zero !== want.zero)
                  flag_mismatch("all_zero", rsp_all_zero, want.zero);
               if (rsp_overflow !== want.ovf)
                  flag_mismatch("overflow", rsp_overflow, want.ovf);
            end
            if (results_seen == 300 || results_seen == 1100) hold_left = 250;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      int fc;
      int pc;
      int lim;
      int phase;
      int budget;
      int k;
      foreach (frac_tab[r, c]) frac_tab[r][c] = '0;
      restart_vector();
      cfg_rows = FCNT_RESET;
      cfg_cols = PCNT_RESET;
      cfg_limit = LIMIT_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: one row, one prime, limit 10000
      plan = {plan, entry(OP_UNUSED, 0, 0, 0, 1, 0, 0, 0)};
      plan = {plan, entry(OP_RESTART, 0, 0, 0, 1, 0, 0, 0)};
      plan = {plan, entry(OP_WRITE, 0, 0, -64, 1, 0, 0, 0)};
      plan = {plan, entry(OP_STEP, 0, 0, 0, 1, 1, 0, 0)};     // 2 cannot pay 2^64
      plan = {plan, entry(OP_STEP, 0, 0, 0, 1, 1, 0, 0)};     // halted, no change
      plan = {plan, entry(OP_WRITE, 0, 0, 63, 1, 1, 0, 0)};
      plan = {plan, entry(OP_RESTART, 0, 0, 0, 1, 0, 0, 0)};
      plan = {plan, entry(OP_STEP, 0, 0, 0, 1, 0, 1, 0)};     // exponent 1 -> 64
      plan = {plan, entry(OP_WRITE, 0, 0, -64, 1, 0, 1, 0)};
      plan = {plan, entry(OP_STEP, 0, 0, 0, 1, 0, 2, 0)};     // exponent 64 -> 0
      plan = {plan, entry(OP_STEP, 0, 0, 0, 1, 1, 2, 1)};     // halts on one
      plan = {plan, entry(OP_WRITE, 31, 7, 63, 1, 1, 2, 1)};
      plan = {plan, entry(OP_WRITE, 31, 7, -64, 1, 1, 2, 1)};
      plan = {plan, entry(OP_WRITE, 21, 2, 42, 0, 0, 0, 0)};
      plan = {plan, entry(OP_UNUSED, 31, 7, -1, 0, 0, 0, 0)};
      plan = {plan, entry(OP_STEP, 10, 5, 21, 0, 0, 0, 0)};
      plan = {plan, entry(OP_RESTART, 31, 7, -1, 0, 0, 0, 0)};
      plan = {plan, entry(OP_WRITE, 0, 0, 1, 0, 0, 0, 0)};
      repeat (3) plan = {plan, entry(OP_STEP, 0, 0, 0, 0, 0, 0, 0)};
      foreach (plan[i])
         offer_item(plan[i].op, plan[i].row, plan[i].col, plan[i].val,
                    plan[i].known, plan[i].want);

      // define the whole table before wider settings scan it
      for (int r = 0; r < MAX_FRACTIONS; r++)
         for (int c = 0; c < MAX_PRIMES; c++)
            offer_item(OP_WRITE, ROW_W'(r), COL_W'(c), ENTRY_W'($urandom), 1'b0, '0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_engine();
         case (phase)
            0: begin fc = 32; pc = 8;  lim = 65535; end
            1: begin fc = 0;  pc = 3;  lim = 100;   end
            2: begin fc = 63; pc = 15; lim = 20;    end
            3: begin fc = 5;  pc = 0;  lim = 30;    end
            4: begin fc = 8;  pc = 4;  lim = 0;     end
            5: begin fc = 1;  pc = 8;  lim = 1;     end
            6: begin fc = 33; pc = 9;  lim = 7;     end
            7: begin fc = 12; pc = 2;  lim = 50;    end
            default: begin
               fc = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(0, 32);
               pc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                : $urandom_range(0, 8);
               k = $urandom_range(0, 3);
               if (k < 2) lim = $urandom_range(1, 60);
               else if (k == 2) lim = $urandom_range(61, 65535);
               else lim = ($urandom_range(0, 1) == 0) ? 0 : 65535;
            end
         endcase
         write_settings(fc, pc, lim);

         if (rows_in_use() > 0 && cols_in_use() > 0)
            repeat ($urandom_range(4, 16))
               offer_item(OP_WRITE, ROW_W'($urandom_range(0, rows_in_use() - 1)),
                          COL_W'($urandom_range(0, cols_in_use() - 1)),
                          program_value(), 1'b0, '0);

         budget = items_sent + $urandom_range(40, 110);
         while (items_sent < budget) begin
            offer_random(OP_RESTART);
            repeat ($urandom_range(2, 45)) begin
               if ($urandom_range(0, 99) < 8) begin
                  k = $urandom_range(0, 2);
                  if (k == 0) offer_random(OP_WRITE);
                  else if (k == 1) offer_random(OP_UNUSED);
                  else offer_random(OP_RESTART);
               end else begin
                  offer_random(OP_STEP);
               end
            end
         end
         phase++;
      end

      drain_engine();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (due_status.size() != 0)
         flag_mismatch("results still pending", due_status.size(), 0);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/fse_pkg.sv
rtl/core/fse_table.sv
rtl/core/fse_vector.sv
rtl/core/fractran_step_engine_unit.sv
tb/sv/testbench.sv
